// ----- src/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros, clocked on clk with async reset arst_n
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression holds on every clock edge out of reset
`define ASSERT_ALWAYS(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// same-cycle implication
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- src/htw_pkg.sv -----
// ----------------------------------------------------------------------------
// htw_pkg
// shared types, codes and defaults for the hashed timer wheel
// ----------------------------------------------------------------------------
package htw_pkg;

	localparam int POOL_SIZE_DEF   = 32;
	localparam int WHEEL_SLOTS_DEF = 1024;
	localparam int MAX_REPORTS     = 32;

	localparam int TICK_W   = 32;
	localparam int DELAY_W  = 24;
	localparam int DATA_W   = 32;
	localparam int HANDLE_W = 5;
	localparam int ACTION_W = 2;
	localparam int KIND_W   = 2;
	localparam int STATUS_W = 2;

	// input actions
	localparam logic [ACTION_W-1:0] ACT_START = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_STOP  = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_TICK  = 2'd2;

	// result kinds
	localparam logic [KIND_W-1:0] KIND_START  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_STOP   = 2'd1;
	localparam logic [KIND_W-1:0] KIND_EXPIRY = 2'd2;

	// result status
	localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
	localparam logic [STATUS_W-1:0] ST_POOL_FULL  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_NOT_ACTIVE = 2'd2;

	// controller to datapath
	typedef struct packed {
		logic latch;
		logic start_begin;
		logic mod_step;
		logic start_commit;
		logic stop_exec;
		logic tick_begin;
		logic scan_next;
		logic take;
		logic push;
		logic push_last;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic free_found;
		logic mod_done;
		logic scan_active;
		logic scan_last;
		logic hit;
		logic n_at_limit;
		logic pend_valid;
		logic out_busy;
	} stat_t;

endpackage

// ----- src/htw_slot_mod.sv -----
// ----------------------------------------------------------------------------
// htw_slot_mod
// reduction of a tick value modulo the wheel size by reciprocal multiply
// ----------------------------------------------------------------------------
module htw_slot_mod #(
	parameter int WHEEL_SLOTS = htw_pkg::WHEEL_SLOTS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                load,
	input  logic                                step,
	input  logic [htw_pkg::TICK_W-1:0]          x,
	output logic [$clog2(WHEEL_SLOTS)-1:0]      rem,
	output logic                                done
);
	import htw_pkg::*;

	localparam int SLOT_W = $clog2(WHEEL_SLOTS);
	localparam int PROD_W = 2 * TICK_W;
	// floor(2^32 / slots): quotient estimate is exact or one low
	localparam longint unsigned RECIP_L = (64'd1 << TICK_W) / WHEEL_SLOTS;
	localparam logic [TICK_W-1:0] RECIP = TICK_W'(RECIP_L);
	localparam logic [TICK_W-1:0] MOD_W = TICK_W'(WHEEL_SLOTS);
	localparam logic [1:0] LAST_STEP = 2'd2;

	logic [TICK_W-1:0] x_q;
	logic [PROD_W-1:0] prod_s1;
	logic [TICK_W-1:0] est_s2;
	logic [SLOT_W-1:0] rem_q;
	logic [1:0]        cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (load) begin
			cnt_q <= '0;
		end else if (step) begin
			cnt_q <= cnt_q + 1'b1;
		end
	end

	// quotient estimate, remainder below twice the modulus, one correction
	always_ff @(posedge clk) begin
		if (load) begin
			x_q <= x;
		end
		if (step) begin
			prod_s1 <= PROD_W'(x_q) * PROD_W'(RECIP);
			est_s2  <= x_q - prod_s1[PROD_W-1:TICK_W] * MOD_W;
			rem_q   <= (est_s2 >= MOD_W) ? SLOT_W'(est_s2 - MOD_W) : SLOT_W'(est_s2);
		end
	end

	assign rem  = rem_q;
	assign done = (cnt_q == LAST_STEP);

endmodule

// ----- src/htw_datapath.sv -----
// ----------------------------------------------------------------------------
// htw_datapath
// timer pool storage, tick and slot counters, scan, pending and output beat
// ----------------------------------------------------------------------------
module htw_datapath #(
	parameter int POOL_SIZE   = htw_pkg::POOL_SIZE_DEF,
	parameter int WHEEL_SLOTS = htw_pkg::WHEEL_SLOTS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  htw_pkg::cmd_t                    cmd,
	output htw_pkg::stat_t                   st,
	input  logic [htw_pkg::DELAY_W-1:0]      delay_ticks,
	input  logic [htw_pkg::DATA_W-1:0]       event_code,
	input  logic [htw_pkg::DATA_W-1:0]       user_tag,
	input  logic [htw_pkg::HANDLE_W-1:0]     handle,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [htw_pkg::KIND_W-1:0]       kind,
	output logic [htw_pkg::STATUS_W-1:0]     status,
	output logic [htw_pkg::HANDLE_W-1:0]     timer_handle,
	output logic [htw_pkg::DATA_W-1:0]       fired_event,
	output logic [htw_pkg::DATA_W-1:0]       fired_tag,
	output logic                             last
);
	import htw_pkg::*;

	localparam int IDX_W  = $clog2(POOL_SIZE);
	localparam int SLOT_W = $clog2(WHEEL_SLOTS);
	localparam int N_W    = $clog2(MAX_REPORTS + 1);
	localparam int EXT_W  = HANDLE_W + IDX_W;

	// latched input beat
	logic [DELAY_W-1:0]  delay_q;
	logic [DATA_W-1:0]   event_q;
	logic [DATA_W-1:0]   tag_q;
	logic [HANDLE_W-1:0] handle_q;

	logic [TICK_W-1:0]    tick_q;
	logic [SLOT_W-1:0]    slot_q;
	logic [POOL_SIZE-1:0] active_q;
	logic [IDX_W-1:0]     alloc_idx_q;
	logic [TICK_W-1:0]    expiry_q;
	logic [IDX_W-1:0]     scan_idx_q;
	logic [N_W-1:0]       n_q;

	// timer memory
	logic [TICK_W-1:0] mem_expiry [POOL_SIZE];
	logic [DATA_W-1:0] mem_event  [POOL_SIZE];
	logic [DATA_W-1:0] mem_tag    [POOL_SIZE];
	logic [SLOT_W-1:0] mem_slot   [POOL_SIZE];
	logic [TICK_W-1:0] rd_expiry_q;
	logic [DATA_W-1:0] rd_event_q;
	logic [DATA_W-1:0] rd_tag_q;
	logic [SLOT_W-1:0] rd_slot_q;

	// pending result
	logic                pend_valid_q;
	logic [KIND_W-1:0]   pend_kind_q;
	logic [STATUS_W-1:0] pend_status_q;
	logic [HANDLE_W-1:0] pend_handle_q;
	logic [DATA_W-1:0]   pend_event_q;
	logic [DATA_W-1:0]   pend_tag_q;

	// output register
	logic                out_valid_q;
	logic [KIND_W-1:0]   out_kind_q;
	logic [STATUS_W-1:0] out_status_q;
	logic [HANDLE_W-1:0] out_handle_q;
	logic [DATA_W-1:0]   out_event_q;
	logic [DATA_W-1:0]   out_tag_q;
	logic                out_last_q;

	logic              free_found;
	logic [IDX_W-1:0]  free_idx;
	logic [TICK_W-1:0] expiry_sum;
	logic [TICK_W-1:0] tick_next;
	logic [TICK_W-1:0] age;
	logic [EXT_W-1:0]  handle_ext;
	logic [IDX_W-1:0]  stop_idx;
	logic              stop_ok;
	logic              hit;
	logic [SLOT_W-1:0] mod_rem;
	logic              mod_done;

	// lowest free entry
	always_comb begin
		free_found = 1'b0;
		free_idx   = '0;
		for (int i = POOL_SIZE - 1; i >= 0; i--) begin
			if (!active_q[i]) begin
				free_found = 1'b1;
				free_idx   = IDX_W'(i);
			end
		end
	end

	always_comb begin
		expiry_sum = tick_q + TICK_W'(delay_q);
		tick_next  = tick_q + 1'b1;
		handle_ext = EXT_W'(handle_q);
		stop_idx   = handle_ext[IDX_W-1:0];
		stop_ok    = (handle_ext < EXT_W'(POOL_SIZE)) && active_q[stop_idx];
		age        = tick_q - rd_expiry_q;
		hit        = active_q[scan_idx_q] && (rd_slot_q == slot_q) && !age[TICK_W-1];
	end

	htw_slot_mod #(
		.WHEEL_SLOTS (WHEEL_SLOTS)
	) u_slot_mod (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (cmd.start_begin),
		.step   (cmd.mod_step),
		.x      (expiry_sum),
		.rem    (mod_rem),
		.done   (mod_done)
	);

	// input latch and start working registers
	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			delay_q  <= delay_ticks;
			event_q  <= event_code;
			tag_q    <= user_tag;
			handle_q <= handle;
		end
		if (cmd.start_begin) begin
			alloc_idx_q <= free_idx;
			expiry_q    <= expiry_sum;
		end
	end

	// memory write on commit, registered read at the scan index
	always_ff @(posedge clk) begin
		if (cmd.start_commit) begin
			mem_expiry[alloc_idx_q] <= expiry_q;
			mem_event[alloc_idx_q]  <= event_q;
			mem_tag[alloc_idx_q]    <= tag_q;
			mem_slot[alloc_idx_q]   <= mod_rem;
		end
		rd_expiry_q <= mem_expiry[scan_idx_q];
		rd_event_q  <= mem_event[scan_idx_q];
		rd_tag_q    <= mem_tag[scan_idx_q];
		rd_slot_q   <= mem_slot[scan_idx_q];
	end

	// tick, slot, active bits, scan position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q     <= '0;
			slot_q     <= '0;
			active_q   <= '0;
			scan_idx_q <= '0;
			n_q        <= '0;
		end else begin
			if (cmd.tick_begin) begin
				tick_q     <= tick_next;
				scan_idx_q <= '0;
				n_q        <= '0;
				if (tick_next == '0) begin
					slot_q <= '0;
				end else if (slot_q == SLOT_W'(WHEEL_SLOTS - 1)) begin
					slot_q <= '0;
				end else begin
					slot_q <= slot_q + 1'b1;
				end
			end
			if (cmd.scan_next) begin
				scan_idx_q <= scan_idx_q + 1'b1;
			end
			if (cmd.start_commit) begin
				active_q[alloc_idx_q] <= 1'b1;
			end
			if (cmd.stop_exec && stop_ok) begin
				active_q[stop_idx] <= 1'b0;
			end
			if (cmd.take) begin
				active_q[scan_idx_q] <= 1'b0;
				n_q                  <= n_q + 1'b1;
			end
		end
	end

	// pending result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_valid_q <= 1'b0;
		end else if ((cmd.start_begin && !free_found) || cmd.start_commit
				|| cmd.stop_exec || cmd.take) begin
			pend_valid_q <= 1'b1;
		end else if (cmd.push) begin
			pend_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start_begin && !free_found) begin
			pend_kind_q   <= KIND_START;
			pend_status_q <= ST_POOL_FULL;
			pend_handle_q <= '0;
			pend_event_q  <= '0;
			pend_tag_q    <= '0;
		end else if (cmd.start_commit) begin
			pend_kind_q   <= KIND_START;
			pend_status_q <= ST_OK;
			pend_handle_q <= HANDLE_W'(alloc_idx_q);
			pend_event_q  <= '0;
			pend_tag_q    <= '0;
		end else if (cmd.stop_exec) begin
			pend_kind_q   <= KIND_STOP;
			pend_status_q <= stop_ok ? ST_OK : ST_NOT_ACTIVE;
			pend_handle_q <= handle_q;
			pend_event_q  <= '0;
			pend_tag_q    <= '0;
		end else if (cmd.take) begin
			pend_kind_q   <= KIND_EXPIRY;
			pend_status_q <= ST_OK;
			pend_handle_q <= HANDLE_W'(scan_idx_q);
			pend_event_q  <= rd_event_q;
			pend_tag_q    <= rd_tag_q;
		end
	end

	// output beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.push) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			out_kind_q   <= pend_kind_q;
			out_status_q <= pend_status_q;
			out_handle_q <= pend_handle_q;
			out_event_q  <= pend_event_q;
			out_tag_q    <= pend_tag_q;
			out_last_q   <= cmd.push_last;
		end
	end

	always_comb begin
		st.free_found  = free_found;
		st.mod_done    = mod_done;
		st.scan_active = active_q[scan_idx_q];
		st.scan_last   = (scan_idx_q == IDX_W'(POOL_SIZE - 1));
		st.hit         = hit;
		st.n_at_limit  = (n_q == N_W'(MAX_REPORTS - 1));
		st.pend_valid  = pend_valid_q;
		st.out_busy    = out_valid_q;
	end

	assign out_valid    = out_valid_q;
	assign kind         = out_kind_q;
	assign status       = out_status_q;
	assign timer_handle = out_handle_q;
	assign fired_event  = out_event_q;
	assign fired_tag    = out_tag_q;
	assign last         = out_last_q;

endmodule

// ----- src/htw_ctrl.sv -----
// ----------------------------------------------------------------------------
// htw_ctrl
// sequencer for start, stop and tick processing
// ----------------------------------------------------------------------------
module htw_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [htw_pkg::ACTION_W-1:0]  action,
	input  htw_pkg::stat_t                st,
	output htw_pkg::cmd_t                 cmd
);
	import htw_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE,
		S_START,
		S_MOD,
		S_COMMIT,
		S_STOP,
		S_PUSH,
		S_TICK,
		S_RD,
		S_EV,
		S_END
	} state_t;

	state_t state_q;
	state_t state_nxt;
	logic   accept;

	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;

	always_comb begin
		cmd       = '0;
		state_nxt = state_q;
		cmd.latch = accept;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					priority if (action == ACT_START) state_nxt = S_START;
					else if (action == ACT_STOP) state_nxt = S_STOP;
					else if (action == ACT_TICK) state_nxt = S_TICK;
					else state_nxt = S_IDLE;
				end
			end
			S_START: begin
				cmd.start_begin = 1'b1;
				state_nxt = st.free_found ? S_MOD : S_PUSH;
			end
			S_MOD: begin
				cmd.mod_step = 1'b1;
				if (st.mod_done) state_nxt = S_COMMIT;
			end
			S_COMMIT: begin
				cmd.start_commit = 1'b1;
				state_nxt = S_PUSH;
			end
			S_STOP: begin
				cmd.stop_exec = 1'b1;
				state_nxt = S_PUSH;
			end
			S_PUSH: begin
				if (!st.out_busy) begin
					cmd.push      = 1'b1;
					cmd.push_last = 1'b1;
					state_nxt     = S_IDLE;
				end
			end
			S_TICK: begin
				cmd.tick_begin = 1'b1;
				state_nxt = S_RD;
			end
			S_RD: begin
				priority if (st.scan_active) begin
					state_nxt = S_EV;
				end else if (st.scan_last) begin
					state_nxt = S_END;
				end else begin
					cmd.scan_next = 1'b1;
				end
			end
			S_EV: begin
				if (st.hit) begin
					if (!(st.pend_valid && st.out_busy)) begin
						cmd.take = 1'b1;
						cmd.push = st.pend_valid;
						if (st.n_at_limit || st.scan_last) begin
							state_nxt = S_END;
						end else begin
							cmd.scan_next = 1'b1;
							state_nxt     = S_RD;
						end
					end
				end else if (st.scan_last) begin
					state_nxt = S_END;
				end else begin
					cmd.scan_next = 1'b1;
					state_nxt     = S_RD;
				end
			end
			S_END: begin
				if (!st.pend_valid) begin
					state_nxt = S_IDLE;
				end else if (!st.out_busy) begin
					cmd.push      = 1'b1;
					cmd.push_last = 1'b1;
					state_nxt     = S_IDLE;
				end
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule

// ----- src/hashed_timer_wheel_core.sv -----
// ----------------------------------------------------------------------------
// hashed_timer_wheel_core
// hashed timer wheel over a bounded pool of timers
// ----------------------------------------------------------------------------
// A start beat stores a timer that expires at current tick + delay_ticks in the
// lowest free pool entry and answers with its handle (or status pool full); a
// stop beat frees the named timer (or answers handle not active); a tick beat
// advances the tick and emits one expiry report per timer whose wheel slot
// matches the new tick and whose expiry is not later, in ascending handle
// order, with last on the final report (a tick with no expiry gives no beat,
// at most 32 reports per tick). One item is worked on at a time. A start
// reduces the wheel slot of the expiry modulo WHEEL_SLOTS by a reciprocal
// multiply, an exact back-multiply and one correcting subtract, each registered
// in turn, then commits the entry; a start into a full pool skips the
// reduction and answers pool full. A tick steps through the pool entry by
// entry: a free entry is passed over, and an active entry is checked once the
// registered read of the timer memory has returned it; the scan ends early
// once the report limit is reached. The sequencer waits whenever the result
// side holds off ready. The next item may be accepted while the last result
// still waits in the output register. No clearing pass: pool entries are
// tracked by flip-flop valid bits cleared at reset, and their stored fields
// are only read once written.
// ----------------------------------------------------------------------------
module hashed_timer_wheel_core #(
	parameter int POOL_SIZE   = htw_pkg::POOL_SIZE_DEF,
	parameter int WHEEL_SLOTS = htw_pkg::WHEEL_SLOTS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// input channel
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [htw_pkg::ACTION_W-1:0]     action,
	input  logic [htw_pkg::DELAY_W-1:0]      delay_ticks,
	input  logic [htw_pkg::DATA_W-1:0]       event_code,
	input  logic [htw_pkg::DATA_W-1:0]       user_tag,
	input  logic [htw_pkg::HANDLE_W-1:0]     handle,
	// result channel
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [htw_pkg::KIND_W-1:0]       kind,
	output logic [htw_pkg::STATUS_W-1:0]     status,
	output logic [htw_pkg::HANDLE_W-1:0]     timer_handle,
	output logic [htw_pkg::DATA_W-1:0]       fired_event,
	output logic [htw_pkg::DATA_W-1:0]       fired_tag,
	output logic                             last
);
	import htw_pkg::*;

	// command and status between sequencer and datapath
	cmd_t  cmd;
	stat_t st;

	// sequencer: accepts beats, steps the start, stop and tick sequences
	htw_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.action   (action),
		.st       (st),
		.cmd      (cmd)
	);

	// datapath: pool valid bits, timer memory, tick and slot counters,
	// slot reduction unit, pending result and output register
	htw_datapath #(
		.POOL_SIZE   (POOL_SIZE),
		.WHEEL_SLOTS (WHEEL_SLOTS)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.st           (st),
		.delay_ticks  (delay_ticks),
		.event_code   (event_code),
		.user_tag     (user_tag),
		.handle       (handle),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.kind         (kind),
		.status       (status),
		.timer_handle (timer_handle),
		.fired_event  (fired_event),
		.fired_tag    (fired_tag),
		.last         (last)
	);

endmodule

// ----- src/htw_checker.sv -----
// ----------------------------------------------------------------------------
// htw_checker
// port-level checks on the timer wheel result channel, bound to the core
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module htw_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic [htw_pkg::KIND_W-1:0]    kind,
	input logic [htw_pkg::STATUS_W-1:0]  status,
	input logic [htw_pkg::HANDLE_W-1:0]  timer_handle,
	input logic [htw_pkg::DATA_W-1:0]    fired_event,
	input logic [htw_pkg::DATA_W-1:0]    fired_tag,
	input logic                          last
);
	import htw_pkg::*;

	logic [KIND_W+STATUS_W+HANDLE_W+2*DATA_W:0] beat;
	logic                                       stall;
	logic                                       answer;
	logic                                       expiry;
	logic                                       full;

	assign beat   = {kind, status, timer_handle, fired_event, fired_tag, last};
	assign stall  = out_valid && !out_ready;
	assign answer = out_valid && (kind == KIND_START || kind == KIND_STOP);
	assign expiry = out_valid && kind == KIND_EXPIRY;
	assign full   = out_valid && status == ST_POOL_FULL;

	// a stalled result beat holds
	`ASSERT_NEXT(a_out_hold, stall, out_valid && $stable(beat), "stalled result beat changed")

	// start and stop answers are always the only beat of their item
	`ASSERT_IMPLIES(a_answer_last, answer, last, "start or stop answer without last")

	// expiry data is only carried by expiry reports
	`ASSERT_IMPLIES(a_answer_zero, answer, fired_event == '0 && fired_tag == '0, "answer data")

	// expiry reports are always ok, pool full only on start with handle zero
	`ASSERT_IMPLIES(a_expiry_ok, expiry, status == ST_OK, "expiry report with bad status")
	`ASSERT_IMPLIES(a_full_handle, full, kind == KIND_START && timer_handle == '0, "bad full")

endmodule

bind hashed_timer_wheel_core htw_checker u_htw_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.kind         (kind),
	.status       (status),
	.timer_handle (timer_handle),
	.fired_event  (fired_event),
	.fired_tag    (fired_tag),
	.last         (last)
);

// ----- sim/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the hashed timer wheel core
// ----------------------------------------------------------------------------
// Start, stop and tick beats are queued by a stimulus process and sent by a
// clocked driver with random gaps. The result side is stalled at random. Each
// accepted beat runs through a timer-pool predictor, and every result beat is
// checked field by field against the oldest predicted answer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
	import htw_pkg::*;

	localparam logic [ACTION_W-1:0] ACT_IGNORED = 2'd3;
	localparam int POOL        = POOL_SIZE_DEF;
	localparam int SLOTS       = WHEEL_SLOTS_DEF;
	localparam int QUIET_LIMIT = 3000;
	localparam int DRAIN_WAIT  = 200;
	localparam int MAX_PRINTED = 64;

	// one queued operation for the input channel
	typedef struct {
		bit [ACTION_W-1:0] act;
		bit [DELAY_W-1:0]  dly;
		bit [DATA_W-1:0]   evt;
		bit [DATA_W-1:0]   tag;
		bit [HANDLE_W-1:0] hnd;
	} timer_op_t;

	// one predicted result beat
	typedef struct packed {
		bit [KIND_W-1:0]   kind;
		bit [STATUS_W-1:0] status;
		bit [HANDLE_W-1:0] hnd;
		bit [DATA_W-1:0]   evt;
		bit [DATA_W-1:0]   tag;
		bit                last;
	} wheel_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                in_valid = 1'b0;
	logic                in_ready;
	logic [ACTION_W-1:0] action = '0;
	logic [DELAY_W-1:0]  delay_ticks = '0;
	logic [DATA_W-1:0]   event_code = '0;
	logic [DATA_W-1:0]   user_tag = '0;
	logic [HANDLE_W-1:0] handle = '0;

	logic                out_valid;
	logic                out_ready = 1'b0;
	logic [KIND_W-1:0]   kind;
	logic [STATUS_W-1:0] status;
	logic [HANDLE_W-1:0] timer_handle;
	logic [DATA_W-1:0]   fired_event;
	logic [DATA_W-1:0]   fired_tag;
	logic                last;

	// pending operations, filled by the stimulus process
	timer_op_t op_queue[$];
	timer_op_t next_op;

	// predicted timer pool and the answers it still owes
	bit [TICK_W-1:0] wheel_tick = '0;
	bit              pool_busy [POOL];
	bit [TICK_W-1:0] pool_due [POOL];
	bit [DATA_W-1:0] pool_event [POOL];
	bit [DATA_W-1:0] pool_tag [POOL];
	wheel_result_t   wheel_answers[$];

	int  mismatches = 0;
	int  quiet_cycles = 0;
	int  src_gap = 0;
	int  sink_stall = 0;
	bit  in_taken = 1'b0;
	// when set, neither side idles
	bit  steady = 1'b0;

	hashed_timer_wheel_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.action       (action),
		.delay_ticks  (delay_ticks),
		.event_code   (event_code),
		.user_tag     (user_tag),
		.handle       (handle),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.kind         (kind),
		.status       (status),
		.timer_handle (timer_handle),
		.fired_event  (fired_event),
		.fired_tag    (fired_tag),
		.last         (last)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// mostly back to back, sometimes a few cycles, rarely a long stretch
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (steady || r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	task automatic note_mismatch(input string msg);
		if (mismatches < MAX_PRINTED)
			$display("[%0t] mismatch: %s", $realtime, msg);
		mismatches++;
	endtask

	task automatic check_field(input string name, input logic [31:0] got,
			input bit [31:0] want);
		if (got !== want)
			note_mismatch($sformatf("%s got %h want %h", name, got, want));
	endtask

	// timer pool predictor: updates the pool and queues the answers one beat owes
	task automatic apply_timer_op(input bit [ACTION_W-1:0] act, input bit [DELAY_W-1:0] dly,
			input bit [DATA_W-1:0] evt, input bit [DATA_W-1:0] tg,
			input bit [HANDLE_W-1:0] hnd);
		wheel_result_t res;
		wheel_result_t held;
		bit have_held;
		bit placed;
		int fired;
		bit [TICK_W-1:0] age;
		res = '0;
		held = '0;
		have_held = 1'b0;
		placed = 1'b0;
		fired = 0;
		case (act)
			ACT_START: begin
				res.kind = KIND_START;
				res.last = 1'b1;
				// lowest free entry wins
				for (int i = 0; i < POOL; i++) begin
					if (!placed && !pool_busy[i]) begin
						pool_busy[i] = 1'b1;
						pool_due[i] = wheel_tick + TICK_W'(dly);
						pool_event[i] = evt;
						pool_tag[i] = tg;
						res.hnd = HANDLE_W'(i);
						placed = 1'b1;
					end
				end
				if (!placed)
					res.status = ST_POOL_FULL;
				wheel_answers = {wheel_answers, res};
			end
			ACT_STOP: begin
				res.kind = KIND_STOP;
				res.hnd = hnd;
				res.last = 1'b1;
				if (pool_busy[hnd])
					pool_busy[hnd] = 1'b0;
				else
					res.status = ST_NOT_ACTIVE;
				wheel_answers = {wheel_answers, res};
			end
			ACT_TICK: begin
				wheel_tick = wheel_tick + 1'b1;
				for (int i = 0; i < POOL; i++) begin
					age = wheel_tick - pool_due[i];
					// slot must match and the expiry must not lie ahead (mod 2^32)
					if (fired < MAX_REPORTS && pool_busy[i]
							&& pool_due[i] % SLOTS == wheel_tick % SLOTS && !age[TICK_W-1]) begin
						pool_busy[i] = 1'b0;
						// hold each report back one step so the final one can get last
						if (have_held)
							wheel_answers = {wheel_answers, held};
						held = '0;
						held.kind = KIND_EXPIRY;
						held.hnd = HANDLE_W'(i);
						held.evt = pool_event[i];
						held.tag = pool_tag[i];
						have_held = 1'b1;
						fired++;
					end
				end
				if (have_held) begin
					held.last = 1'b1;
					wheel_answers = {wheel_answers, held};
				end
			end
			default: ;
		endcase
	endtask

	// driver: new beat at the falling edge once the previous one is taken
	always @(negedge clk) begin
		if (!(in_valid && !in_taken)) begin
			if (src_gap != 0) begin
				in_valid <= 1'b0;
				src_gap <= src_gap - 1;
			end else if (op_queue.size() != 0) begin
				next_op = op_queue.pop_front();
				in_valid <= 1'b1;
				action <= next_op.act;
				delay_ticks <= next_op.dly;
				event_code <= next_op.evt;
				user_tag <= next_op.tag;
				handle <= next_op.hnd;
				src_gap <= pick_gap();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// result side back-pressure
	always @(negedge clk) begin
		if (sink_stall != 0) begin
			out_ready <= 1'b0;
			sink_stall <= sink_stall - 1;
		end else begin
			out_ready <= 1'b1;
			sink_stall <= ($urandom_range(0, 3) == 0) ? pick_gap() : 0;
		end
	end

	// monitor: predicts on every input beat, checks every result beat
	always @(posedge clk) begin
		wheel_result_t want;
		if (!arst_n) begin
			in_taken <= 1'b0;
			quiet_cycles <= 0;
		end else begin
			in_taken <= in_valid && in_ready;
			if (in_valid && in_ready)
				apply_timer_op(action, delay_ticks, event_code, user_tag, handle);
			if (out_valid && out_ready) begin
				if (wheel_answers.size() == 0) begin
					note_mismatch($sformatf("unexpected result kind %0d handle %0d",
						kind, timer_handle));
				end else begin
					want = wheel_answers.pop_front();
					check_field("kind", 32'(kind), 32'(want.kind));
					check_field("status", 32'(status), 32'(want.status));
					check_field("timer_handle", 32'(timer_handle), 32'(want.hnd));
					check_field("fired_event", fired_event, want.evt);
					check_field("fired_tag", fired_tag, want.tag);
					check_field("last", 32'(last), 32'(want.last));
				end
			end
			// watchdog on stretches with no beat on either side
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= QUIET_LIMIT) begin
				$display("timeout: no beat for %0d cycles", QUIET_LIMIT);
				$display("Simulation FAILED");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	task automatic queue_op(input bit [ACTION_W-1:0] act, input bit [DELAY_W-1:0] dly,
			input bit [DATA_W-1:0] evt, input bit [DATA_W-1:0] tg,
			input bit [HANDLE_W-1:0] hnd);
		timer_op_t op;
		op.act = act;
		op.dly = dly;
		op.evt = evt;
		op.tag = tg;
		op.hnd = hnd;
		op_queue = {op_queue, op};
	endtask

	// sender holds back until every queued beat is taken and answered
	task automatic wait_idle();
		do
			@(posedge clk);
		while (op_queue.size() != 0 || in_valid || wheel_answers.size() != 0);
	endtask

	// random mix of operations, stops aimed mostly at timers live right now
	task automatic queue_random_mix(input int count);
		int live[$];
		int r;
		bit [DELAY_W-1:0] dly;
		foreach (pool_busy[i])
			if (pool_busy[i])
				live = {live, i};
		repeat (count) begin
			r = $urandom_range(0, 99);
			if (r < 40) begin
				r = $urandom_range(0, 99);
				if (r < 55)
					dly = DELAY_W'($urandom_range(1, 8));
				else if (r < 70)
					dly = DELAY_W'($urandom_range(9, 1500));
				else if (r < 82)
					dly = DELAY_W'(SLOTS + $urandom_range(1, 8));
				else if (r < 95)
					dly = DELAY_W'($urandom);
				else
					dly = '0;
				queue_op(ACT_START, dly, $urandom, $urandom, HANDLE_W'($urandom));
			end else if (r < 65) begin
				if (live.size() != 0 && $urandom_range(0, 9) < 7)
					queue_op(ACT_STOP, DELAY_W'($urandom), $urandom, $urandom,
						HANDLE_W'(live[$urandom_range(0, live.size() - 1)]));
				else
					queue_op(ACT_STOP, DELAY_W'($urandom), $urandom, $urandom,
						HANDLE_W'($urandom));
			end else if (r < 95) begin
				queue_op(ACT_TICK, DELAY_W'($urandom), $urandom, $urandom, HANDLE_W'($urandom));
			end else begin
				queue_op(ACT_IGNORED, DELAY_W'($urandom), $urandom, $urandom,
					HANDLE_W'($urandom));
			end
		end
	endtask

	initial begin
		foreach (pool_busy[i]) begin
			pool_busy[i] = 1'b0;
			pool_due[i] = '0;
			pool_event[i] = '0;
			pool_tag[i] = '0;
		end
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: empty pool, field extremes, each special case
		queue_op(ACT_TICK, '0, '0, '0, '0);                       // tick with no expiry
		queue_op(ACT_STOP, '0, '0, '0, 5'd0);                     // stop of an idle entry
		queue_op(ACT_STOP, '1, '1, '1, 5'd31);
		queue_op(ACT_START, '0, '0, '0, '0);                      // zero delay, waits a full turn
		queue_op(ACT_START, '1, '1, '1, '1);                      // longest delay
		queue_op(ACT_START, 24'd1, 32'hA5A5_A5A5, 32'h5A5A_5A5A, '0);
		queue_op(ACT_START, 24'(SLOTS + 1), 32'h1, 32'h2, '0);    // same slot, not yet due
		queue_op(ACT_START, 24'd2, 32'hDEAD_0004, 32'hBEEF_0004, '0);
		queue_op(ACT_START, 24'd2, 32'hDEAD_0005, 32'hBEEF_0005, '0);
		queue_op(ACT_TICK, '0, '0, '0, '0);
		queue_op(ACT_STOP, '0, '0, '0, 5'd4);                     // good stop
		queue_op(ACT_STOP, '0, '0, '0, 5'd4);                     // same handle again
		queue_op(ACT_IGNORED, '1, '1, '1, '1);                    // unknown action
		queue_op(ACT_TICK, '0, '0, '0, '0);
		queue_op(ACT_STOP, '0, '0, '0, 5'd1);
		queue_op(ACT_STOP, '0, '0, '0, 5'd3);
		queue_op(ACT_STOP, '0, '0, '0, 5'd0);
		queue_op(ACT_STOP, '0, '0, '0, 5'd2);                     // already fired
		wait_idle();

		// fill the whole pool with one expiry, overflow it, then fire all at once
		steady = 1'b1;
		repeat (POOL + 1)
			queue_op(ACT_START, 24'd3, $urandom, $urandom, HANDLE_W'($urandom));
		repeat (3)
			queue_op(ACT_TICK, DELAY_W'($urandom), $urandom, $urandom, HANDLE_W'($urandom));
		wait_idle();

		// random mix in batches, one with no idling at all
		for (int b = 0; b < 4; b++) begin
			steady = (b % 3 == 2);
			queue_random_mix(19);
			wait_idle();
		end
		steady = 1'b0;

		// let a trailing tick with no report finish inside the core
		repeat (DRAIN_WAIT) @(posedge clk);
		if (wheel_answers.size() != 0)
			note_mismatch($sformatf("%0d results never arrived", wheel_answers.size()));
		if (mismatches == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
